// ===== rtl/core/slss_pkg.sv =====
// ----------------------------------------------------------------------------
// slss_pkg
// Shared types and constants for the sprite line scan and sort block.
// ----------------------------------------------------------------------------
package slss_pkg;

	localparam int TABLE_ENTRIES = 40;
	localparam int MAX_PER_LINE  = 10;
	localparam int QUEUE_DEPTH   = 2;

	localparam int IDX_W   = 6;
	localparam int TBL_AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_PER_LINE + 1);
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	localparam logic [8:0] LINE_OFFSET  = 9'd16;
	localparam logic [8:0] SHORT_HEIGHT = 9'd8;
	localparam logic [8:0] TALL_HEIGHT  = 9'd16;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SCAN  = 1'b1;

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] tile;
		logic [7:0] flags;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		entry_t           ent;
	} sel_t;

	typedef struct packed {
		logic              scan;
		logic [TBL_AW-1:0] addr;
		entry_t            ent;
		logic [7:0]        line;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic last;
		sel_t sel;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/core/slss_front.sv =====
// ----------------------------------------------------------------------------
// slss_front
// Input side: unpacks requests, drops writes beyond the table, queues the rest.
// ----------------------------------------------------------------------------
module slss_front
	import slss_pkg::*;
(
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	input  logic                 q_full,
	output logic                 q_push,
	output cmd_t                 q_cmd
);

	logic [IDX_W-1:0] idx;
	logic             in_range;

	assign idx      = s_tdata[5:0];
	assign in_range = {1'b0, idx} < (IDX_W + 1)'(TABLE_ENTRIES);
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && (s_tuser[0] == ACT_SCAN || in_range);

	always_comb begin
		q_cmd.scan      = (s_tuser[0] == ACT_SCAN);
		q_cmd.addr      = idx[TBL_AW-1:0];
		q_cmd.ent.y     = s_tdata[13:6];
		q_cmd.ent.x     = s_tdata[21:14];
		q_cmd.ent.tile  = s_tdata[29:22];
		q_cmd.ent.flags = s_tdata[37:30];
		q_cmd.line      = s_tdata[45:38];
	end

endmodule

// ===== rtl/core/slss_queue.sv =====
// ----------------------------------------------------------------------------
// slss_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module slss_queue
	import slss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_vld,
	output cmd_t head_cmd
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/slss_back.sv =====
// ----------------------------------------------------------------------------
// slss_back
// Table storage, line scan with sorted insertion, and result output register.
// ----------------------------------------------------------------------------
module slss_back
	import slss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic tall,
	input  logic q_vld,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic out_vld,
	input  logic out_rdy,
	output result_t out_res
);

	state_t state_q, state_d;

	entry_t            mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] ent_vld_q;

	logic [TBL_AW-1:0] rd_addr_q;
	logic [7:0]        line_q;
	logic              rd_en, wr_en, emit;

	logic              rd_vld_s1;
	logic              ent_vld_s1;
	logic [TBL_AW-1:0] rd_idx_s1;
	entry_t            rd_data_s1;

	sel_t              list_q [MAX_PER_LINE];
	logic [CNT_W-1:0]  cnt_q;

	logic              out_vld_q;
	result_t           out_res_q;

	logic [8:0]        target, height, y_ext;
	logic              hit, insert;
	logic [MAX_PER_LINE-1:0] gt;
	sel_t              new_sel;

	assign out_vld = out_vld_q;
	assign out_res = out_res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_vld) begin
					q_pop = 1'b1;
					if (q_cmd.scan) begin
						state_d = ST_SCAN;
					end else begin
						wr_en = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (rd_addr_q == TBL_AW'(TABLE_ENTRIES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_vld_q || out_rdy) begin
					emit = 1'b1;
					if (cnt_q <= CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// attribute table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[q_cmd.addr] <= q_cmd.ent;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr_q];
			rd_idx_s1  <= rd_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q  <= '0;
			rd_vld_s1  <= 1'b0;
			ent_vld_s1 <= 1'b0;
			rd_addr_q  <= '0;
			line_q     <= '0;
		end else begin
			if (wr_en) begin
				ent_vld_q[q_cmd.addr] <= 1'b1;
			end
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				ent_vld_s1 <= ent_vld_q[rd_addr_q];
			end
			if (state_q == ST_IDLE) begin
				rd_addr_q <= '0;
				if (q_vld && q_cmd.scan) begin
					line_q <= q_cmd.line;
				end
			end else if (rd_en) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end
		end
	end

	// span test on the entry read last cycle
	assign target  = {1'b0, line_q} + LINE_OFFSET;
	assign height  = tall ? TALL_HEIGHT : SHORT_HEIGHT;
	assign y_ext   = {1'b0, rd_data_s1.y};
	assign hit     = (y_ext <= target) && (y_ext + height > target);
	assign insert  = rd_vld_s1 && ent_vld_s1 && (rd_data_s1.x != 8'd0) && hit &&
	                 (cnt_q < CNT_W'(MAX_PER_LINE));
	assign new_sel = '{idx: IDX_W'(rd_idx_s1), ent: rd_data_s1};

	always_comb begin
		for (int j = 0; j < MAX_PER_LINE; j++) begin
			gt[j] = (CNT_W'(j) < cnt_q) && (list_q[j].ent.x > rd_data_s1.x);
		end
	end

	// sorted list: stable insertion, drained from slot zero
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_PER_LINE; j++) begin
			if (insert) begin
				if (gt[j] || CNT_W'(j) == cnt_q) begin
					if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
						list_q[j] <= list_q[(j > 0) ? j - 1 : 0];
					end else begin
						list_q[j] <= new_sel;
					end
				end
			end else if (emit && j < MAX_PER_LINE - 1) begin
				list_q[j] <= list_q[(j < MAX_PER_LINE - 1) ? j + 1 : j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (state_q == ST_IDLE && q_vld && q_cmd.scan) begin
				cnt_q <= '0;
			end else if (insert) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (emit && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cnt_q == '0) begin
				out_res_q.found <= 1'b0;
				out_res_q.last  <= 1'b1;
				out_res_q.sel   <= '0;
			end else begin
				out_res_q.found <= 1'b1;
				out_res_q.last  <= (cnt_q == CNT_W'(1));
				out_res_q.sel   <= list_q[0];
			end
		end
	end

endmodule

// ===== rtl/core/sprite_line_scan_select_sort.sv =====
// ----------------------------------------------------------------------------
// sprite_line_scan_select_sort
// Sprite attribute table with per-line selection and x-ordered output.
// ----------------------------------------------------------------------------
// A write request (tuser 0) stores one 32-bit entry; indexes beyond the
// table are dropped at the input. A scan request (tuser 1) reads the table
// one entry per cycle through the single table read port, inserting each hit
// into a sorted list, then sends the hits in ascending x one per cycle while
// the sink takes them, at least one result per scan (a not-found result when
// nothing hits). A two-entry queue lets new requests be taken while a scan
// runs, and an output register holds a result until the sink takes it. The
// table acts as empty after reset (per-entry valid bits are cleared), with
// no clearing pass.
module sprite_line_scan_select_sort
	import slss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,     // tall_sprites
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,      // entry_index, entry_y, entry_x,
	                                           // entry_tile, entry_flags, scan_line
	input  logic [0:0]           s_tuser,      // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,      // sprite_index, sprite_y, sprite_x,
	                                           // sprite_tile, sprite_flags
	output logic [0:0]           m_tuser,      // found
	output logic                 m_tlast
);

	logic    tall_q;
	logic    q_full, q_push, q_pop, q_vld;
	cmd_t    push_cmd, head_cmd;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_q <= 1'b0;
		end else if (cfg_valid) begin
			tall_q <= cfg_data;
		end
	end

	slss_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	slss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_vld (q_vld),
		.head_cmd (head_cmd)
	);

	slss_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tall    (tall_q),
		.q_vld   (q_vld),
		.q_cmd   (head_cmd),
		.q_pop   (q_pop),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.out_res (res)
	);

	assign m_tdata    = {2'b00, res.sel.ent.flags, res.sel.ent.tile, res.sel.ent.x,
	                     res.sel.ent.y, res.sel.idx};
	assign m_tuser[0] = res.found;
	assign m_tlast    = res.last;

endmodule

// ===== verif/slss_checker.sv =====
// ----------------------------------------------------------------------------
// sprite_line_checker
// Watches the config, request and result channels of the sprite line scan
// block. It keeps its own copy of the attribute table and height setting,
// works out the x-ordered sprite list for every accepted scan request, and
// compares each accepted result with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module sprite_line_checker
	import slss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic [0:0]           m_tuser,
	input  logic                 m_tlast,
	output int                   mismatches,
	output int                   hits_due
);

	entry_t  sprite_table [TABLE_ENTRIES];
	logic    tall;
	result_t due_hits [$];

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// walk the table in index order, keep up to MAX_PER_LINE hits sorted by x
	task automatic select_line_sprites(input logic [7:0] line);
		sel_t       picks [MAX_PER_LINE];
		int         count;
		int         j;
		logic [8:0] target;
		logic [8:0] height;
		logic [8:0] top;
		result_t    hit;
		count  = 0;
		target = {1'b0, line} + LINE_OFFSET;
		height = tall ? TALL_HEIGHT : SHORT_HEIGHT;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (sprite_table[i].x == 8'd0)
				continue;
			if (count >= MAX_PER_LINE)
				break;
			top = {1'b0, sprite_table[i].y};
			if (top <= target && top + height > target) begin
				j = count;
				while (j > 0 && picks[j-1].ent.x > sprite_table[i].x) begin
					picks[j] = picks[j-1];
					j--;
				end
				picks[j].idx = IDX_W'(i);
				picks[j].ent = sprite_table[i];
				count++;
			end
		end
		if (count == 0) begin
			hit      = '0;
			hit.last = 1'b1;
			due_hits.insert(due_hits.size(), hit);
		end else begin
			for (int k = 0; k < count; k++) begin
				hit.found = 1'b1;
				hit.last  = (k == count - 1);
				hit.sel   = picks[k];
				due_hits.insert(due_hits.size(), hit);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				sprite_table[i] = '0;
			tall = 1'b0;
			due_hits.delete();
			mismatches = 0;
			hits_due = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				tall = cfg_data;
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == ACT_SCAN) begin
					select_line_sprites(s_tdata[45:38]);
				end else if (s_tdata[5:0] < TABLE_ENTRIES) begin
					sprite_table[s_tdata[5:0]] = {s_tdata[13:6], s_tdata[21:14],
						s_tdata[29:22], s_tdata[37:30]};
				end
			end
			if (m_tvalid && m_tready) begin
				if (due_hits.size() == 0) begin
					$display("%0t: result with none expected, got found %0h idx %0h data %0h",
						$time, m_tuser, m_tdata[5:0], m_tdata);
					mismatches++;
				end else begin
					want = due_hits.pop_front();
					check_field("found", want.found, m_tuser[0]);
					check_field("sprite_index", want.sel.idx, m_tdata[5:0]);
					check_field("sprite_y", want.sel.ent.y, m_tdata[13:6]);
					check_field("sprite_x", want.sel.ent.x, m_tdata[21:14]);
					check_field("sprite_tile", want.sel.ent.tile, m_tdata[29:22]);
					check_field("sprite_flags", want.sel.ent.flags, m_tdata[37:30]);
					check_field("last", want.last, m_tlast);
				end
			end
			hits_due = due_hits.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sprite line scan block: directed table writes
// and scans at the edges, then random sprite clusters around chosen lines
// with scans of those lines, mixed with stray writes and scans, over several
// idle/stall phases and both sprite heights.
// ----------------------------------------------------------------------------
module tb
	import slss_pkg::*;
();

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_data  = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [0:0]           s_tuser   = '0;
	logic                 m_tready  = 1'b0;
	logic                 cfg_ready;
	logic                 s_tready;
	logic                 m_tvalid;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0]           m_tuser;
	logic                 m_tlast;

	int   mismatches;
	int   hits_due;
	int   idle_pct  = 0;
	int   stall_pct = 0;
	logic tall      = 1'b0;

	sprite_line_scan_select_sort uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	sprite_line_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .mismatches(mismatches), .hits_due(hits_due)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input logic act, input logic [5:0] idx, input logic [7:0] y,
		input logic [7:0] x, input logic [7:0] tile, input logic [7:0] flags,
		input logic [7:0] line);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {2'b00, line, flags, tile, x, y, idx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic put_entry(input logic [5:0] idx, input logic [7:0] y, input logic [7:0] x,
		input logic [7:0] tile, input logic [7:0] flags);
		send_req(ACT_WRITE, idx, y, x, tile, flags, 8'($urandom));
	endtask

	task automatic scan_line(input logic [7:0] line);
		send_req(ACT_SCAN, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), line);
	endtask

	task automatic set_height(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		tall = v;
	endtask

	// hold off requests until every result is in and trailing writes retire
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (hits_due == 0);
		@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic run_mix(input int n_items);
		int         sent;
		int         r;
		int         target;
		int         lo;
		int         hi;
		int         cnt;
		int         xr;
		logic [7:0] line;
		logic [7:0] y;
		logic [7:0] x;
		logic [5:0] idx;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 70) begin
				// cluster of sprites around one line, then scan it
				line   = 8'($urandom_range(255));
				target = line + 16;
				lo     = target - (tall ? 16 : 8) + 1;
				hi     = (target > 255) ? 255 : target;
				if (lo < 0)
					lo = 0;
				cnt = $urandom_range(14, 1);
				for (int k = 0; k < cnt; k++) begin
					if ($urandom_range(99) < 80 && lo <= hi)
						y = 8'($urandom_range(hi, lo));
					else
						y = 8'($urandom_range(255));
					xr = $urandom_range(99);
					if (xr < 8)
						x = 8'd0;
					else if (xr < 50)
						x = 8'(8 * $urandom_range(4, 1));
					else
						x = 8'($urandom_range(255, 1));
					idx = 6'(($urandom_range(99) < 6) ? $urandom_range(63, 40)
						: $urandom_range(39));
					put_entry(idx, y, x, 8'($urandom), 8'($urandom));
					sent++;
				end
				scan_line(line);
				sent++;
				if ($urandom_range(99) < 30) begin
					scan_line(8'(line + $urandom_range(tall ? 16 : 8)));
					sent++;
				end
			end else if (r < 85) begin
				put_entry(6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
				sent++;
			end else begin
				scan_line(8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_height(1'b0);
		scan_line(8'd0);                                    // empty table
		put_entry(6'd0, 8'd16, 8'd255, 8'hFF, 8'hFF);
		put_entry(6'd39, 8'd16, 8'd1, 8'h00, 8'h00);
		put_entry(6'd63, 8'd16, 8'd2, 8'hAA, 8'h55);        // beyond table
		put_entry(6'd40, 8'd16, 8'd3, 8'h55, 8'hAA);        // beyond table
		put_entry(6'd5, 8'd16, 8'd0, 8'h12, 8'h34);         // hidden
		put_entry(6'd6, 8'd16, 8'd1, 8'h81, 8'h18);         // x tie with 39
		scan_line(8'd0);
		scan_line(8'd7);
		scan_line(8'd8);
		put_entry(6'd10, 8'd255, 8'd128, 8'h5A, 8'hA5);
		scan_line(8'd246);                                  // bottom edge, no wrap
		scan_line(8'd239);
		scan_line(8'd247);
		scan_line(8'd255);
		settle();
		set_height(1'b1);
		scan_line(8'd239);
		scan_line(8'd254);
		scan_line(8'd255);
		scan_line(8'd8);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 46;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 46;
				end
				default: begin
					idle_pct  = 8;
					stall_pct = 8;
				end
			endcase
			set_height(ph >= 4);
			run_mix(38);
		end

		settle();
		if (mismatches == 0 && hits_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/slss_pkg.sv
rtl/core/slss_front.sv
rtl/core/slss_queue.sv
rtl/core/slss_back.sv
rtl/core/sprite_line_scan_select_sort.sv
verif/slss_checker.sv
verif/tb.sv
